// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked at every clock edge outside reset.
`define PLQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define PLQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define PLQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/plq_pkg.sv -----
`default_nettype none
package plq_pkg;

    localparam int unsigned POOL_SLOTS_DEFAULT = 256;
    localparam int unsigned SIZE_BITS_DEFAULT  = 32;

    localparam int unsigned SLOT_BITS    = 8;
    localparam int unsigned SIZE_IN_BITS = 32;
    localparam int unsigned VOL_BITS     = 40;
    localparam int unsigned COUNT_BITS   = 9;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_UNLINK = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] STAT_DONE       = 2'd0;
    localparam logic [1:0] STAT_QUEUED     = 2'd1;
    localparam logic [1:0] STAT_NOT_QUEUED = 2'd2;

    typedef struct packed {
        logic [1:0]              operation;
        logic [SLOT_BITS-1:0]    node_slot;
        logic [SIZE_IN_BITS-1:0] order_size;
    } t_plq_in;

    typedef struct packed {
        logic [VOL_BITS-1:0]   total_volume;
        logic [COUNT_BITS-1:0] order_count;
        logic                  level_empty;
        logic [SLOT_BITS-1:0]  head_slot_out;
        logic [SLOT_BITS-1:0]  tail_slot_out;
        logic [1:0]            status;
    } t_plq_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // take the input item and read its slot's links and size
        logic execute;  // update links, totals and membership, load the result
    } t_plq_cmd;

endpackage
`default_nettype wire

// ----- rtl/plq_ctrl.sv -----
`default_nettype none
module plq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output plq_pkg::t_plq_cmd o_cmd
);
    import plq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_plq_state;

    t_plq_state r_state;
    t_plq_state n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_plq_cmd   cmd;

    always_comb begin
        n_state     = r_state;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // The result register must be free or emptying this cycle.
                cmd.execute = !r_out_valid || i_out_ready;
                if (cmd.execute) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.execute) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule
`default_nettype wire

// ----- rtl/plq_datapath.sv -----
`default_nettype none
module plq_datapath #(
    parameter int unsigned POOL_SLOTS = plq_pkg::POOL_SLOTS_DEFAULT,
    parameter int unsigned SIZE_BITS  = plq_pkg::SIZE_BITS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  plq_pkg::t_plq_cmd i_cmd,
    input  plq_pkg::t_plq_in  i_in,
    output plq_pkg::t_plq_out o_out
);
    import plq_pkg::*;

    localparam int unsigned SLOT_W = $clog2(POOL_SLOTS);

    // Link and size stores. The end links of the queue are not kept valid: the
    // head has no predecessor and the tail no successor, so those entries may be stale.
    logic [SLOT_W-1:0]    mem_next [POOL_SLOTS];
    logic [SLOT_W-1:0]    mem_prev [POOL_SLOTS];
    logic [SIZE_BITS-1:0] mem_size [POOL_SLOTS];

    t_plq_in              r_in;
    logic [SLOT_W-1:0]    r_rd_next;
    logic [SLOT_W-1:0]    r_rd_prev;
    logic [SIZE_BITS-1:0] r_rd_size;
    logic [SLOT_W-1:0]    r_head;
    logic [SLOT_W-1:0]    r_tail;
    logic [VOL_BITS-1:0]  r_vol;
    logic [COUNT_BITS-1:0] r_count;
    logic [POOL_SLOTS-1:0] r_in_queue;
    t_plq_out             r_out;

    logic [SLOT_W-1:0]    n_head;
    logic [SLOT_W-1:0]    n_tail;
    logic [VOL_BITS-1:0]  n_vol;
    logic [COUNT_BITS-1:0] n_count;
    logic [POOL_SLOTS-1:0] n_in_queue;
    t_plq_out             n_out;

    logic [31:0]          cap_ext;
    logic [SLOT_W-1:0]    cap_idx;
    logic [31:0]          slot_ext;
    logic [SLOT_W-1:0]    idx;
    logic                 in_range;
    logic                 queued;
    logic [63:0]          size_ext;
    logic [SIZE_BITS-1:0] size_cut;
    logic [63:0]          add_ext;
    logic [63:0]          sub_ext;
    logic                 is_head;
    logic                 is_tail;
    logic                 count_zero;
    logic                 do_append;
    logic                 do_unlink;
    logic                 do_clear;
    logic [1:0]           status;
    logic [31:0]          head_ext;
    logic [31:0]          tail_ext;

    logic                 we_next;
    logic [SLOT_W-1:0]    wa_next;
    logic [SLOT_W-1:0]    wd_next;
    logic                 we_prev;
    logic [SLOT_W-1:0]    wa_prev;
    logic [SLOT_W-1:0]    wd_prev;

    assign cap_ext = 32'(i_in.node_slot);
    assign cap_idx = cap_ext[SLOT_W-1:0];

    always_comb begin
        slot_ext   = 32'(r_in.node_slot);
        idx        = slot_ext[SLOT_W-1:0];
        in_range   = slot_ext < 32'(POOL_SLOTS);
        queued     = in_range && r_in_queue[idx];
        size_ext   = 64'(r_in.order_size);
        size_cut   = size_ext[SIZE_BITS-1:0];
        add_ext    = 64'(size_cut);
        sub_ext    = 64'(r_rd_size);
        is_head    = (idx == r_head);
        is_tail    = (idx == r_tail);
        count_zero = (r_count == '0);

        do_append = i_cmd.execute && (r_in.operation == OP_APPEND) && in_range && !queued;
        do_unlink = i_cmd.execute && (r_in.operation == OP_UNLINK) && queued;
        do_clear  = i_cmd.execute && (r_in.operation == OP_CLEAR);

        priority if ((r_in.operation == OP_APPEND) && !in_range) begin
            status = STAT_NOT_QUEUED;
        end else if ((r_in.operation == OP_APPEND) && queued) begin
            status = STAT_QUEUED;
        end else if ((r_in.operation == OP_UNLINK) && !queued) begin
            status = STAT_NOT_QUEUED;
        end else begin
            status = STAT_DONE;
        end
    end

    // State update.
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_vol      = r_vol;
        n_count    = r_count;
        n_in_queue = r_in_queue;
        if (do_clear) begin
            n_head     = '0;
            n_tail     = '0;
            n_vol      = '0;
            n_count    = '0;
            n_in_queue = '0;
        end else if (do_append) begin
            if (count_zero) begin
                n_head = idx;
            end
            n_tail          = idx;
            n_vol           = r_vol + add_ext[VOL_BITS-1:0];
            n_count         = r_count + COUNT_BITS'(1);
            n_in_queue[idx] = 1'b1;
        end else if (do_unlink) begin
            n_vol           = r_vol - sub_ext[VOL_BITS-1:0];
            n_in_queue[idx] = 1'b0;
            if (!count_zero) begin
                n_count = r_count - COUNT_BITS'(1);
            end
            if (n_count == '0) begin
                n_head = '0;
                n_tail = '0;
            end else begin
                if (is_head) begin
                    n_head = r_rd_next;
                end
                if (is_tail) begin
                    n_tail = r_rd_prev;
                end
            end
        end
    end

    // At most one write to each link store per item.
    always_comb begin
        we_next = 1'b0;
        wa_next = r_tail;
        wd_next = idx;
        we_prev = 1'b0;
        wa_prev = idx;
        wd_prev = r_tail;
        if (do_append) begin
            we_next = !count_zero;
            we_prev = 1'b1;
        end else if (do_unlink) begin
            we_next = !is_head;
            wa_next = r_rd_prev;
            wd_next = r_rd_next;
            we_prev = !is_tail;
            wa_prev = r_rd_next;
            wd_prev = r_rd_prev;
        end
    end

    always_comb begin
        head_ext            = 32'(n_head);
        tail_ext            = 32'(n_tail);
        n_out.total_volume  = n_vol;
        n_out.order_count   = n_count;
        n_out.level_empty   = (n_count == '0);
        n_out.head_slot_out = head_ext[SLOT_BITS-1:0];
        n_out.tail_slot_out = tail_ext[SLOT_BITS-1:0];
        n_out.status        = status;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_next <= mem_next[cap_idx];
            r_rd_prev <= mem_prev[cap_idx];
            r_rd_size <= mem_size[cap_idx];
        end
        if (we_next) begin
            mem_next[wa_next] <= wd_next;
        end
        if (we_prev) begin
            mem_prev[wa_prev] <= wd_prev;
        end
        if (do_append) begin
            mem_size[idx] <= size_cut;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_vol      <= '0;
            r_count    <= '0;
            r_in_queue <= '0;
        end else if (i_cmd.execute) begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_vol      <= n_vol;
            r_count    <= n_count;
            r_in_queue <= n_in_queue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in;
        end
        if (i_cmd.execute) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule
`default_nettype wire

// ----- rtl/price_level_order_queue.sv -----
`default_nettype none
// Channel  Direction  Handshake                   Payload
// input    in         i_in_valid / o_in_ready     i_in  (plq_pkg::t_plq_in)
// result   out        o_out_valid / i_out_ready   o_out (plq_pkg::t_plq_out)
//
// In the cycle an item is accepted, the link and size stores are read at its
// slot into registers; in the execute state that follows, held while an
// untaken result waits, at most one entry of each link store is written and
// the totals and the result register update. The membership bits sit in
// flip-flops and clear at once on reset, so there is no sweep. A result not
// taken does not block accepting the next item, which waits in execute.
`include "assert_macros.svh"
module price_level_order_queue #(
    parameter int unsigned POOL_SLOTS = plq_pkg::POOL_SLOTS_DEFAULT,
    parameter int unsigned SIZE_BITS  = plq_pkg::SIZE_BITS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  plq_pkg::t_plq_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output plq_pkg::t_plq_out o_out
);
    import plq_pkg::*;

    t_plq_cmd cmd;

    // The controller sequences the capture and execute cycles and owns the
    // result valid flag.
    plq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // The datapath holds the queue: head and tail, membership bits, totals
    // and the link and size stores.
    plq_datapath #(
        .POOL_SLOTS (POOL_SLOTS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    // An accepted item keeps the input closed for its execute cycle.
    `PLQ_ASSERT(a_one_item, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "input open during execute")
    // A waiting result is never overwritten.
    `PLQ_ASSERT(a_no_overwrite, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |-> !cmd.execute, "result overwritten")
    // Capture and execute belong to different cycles.
    `PLQ_ASSERT_ALWAYS(a_cmd_excl, i_clk, !(cmd.capture && cmd.execute), "capture and execute together")
    // The empty flag agrees with the order count.
    `PLQ_ASSERT(a_empty_flag, i_clk, i_rst_n, o_out_valid |-> (o_out.level_empty == (o_out.order_count == '0)), "empty flag mismatch")

endmodule
`default_nettype wire
